[rtl/core/wrp_pkg.sv]
// shared types and constants of the weighted random picker
package wrp_pkg;
   localparam int MAX_WEIGHT   = 16;
   localparam int BUCKET_DEPTH = 16;
   localparam int ID_WIDTH     = 32;
   localparam int STORE_SIZE   = MAX_WEIGHT * BUCKET_DEPTH;
   localparam int BKT_BITS     = $clog2(MAX_WEIGHT);
   localparam int SLOT_BITS    = $clog2(BUCKET_DEPTH);
   localparam int ADDR_BITS    = BKT_BITS + SLOT_BITS;
   localparam int WGT_BITS     = $clog2(MAX_WEIGHT + 1);
   localparam int CNT_BITS     = $clog2(BUCKET_DEPTH + 1);
   localparam int TW_BITS      = 12;
   localparam int DRAW_BITS    = 32;
   localparam int BIT_CNT_BITS = $clog2(DRAW_BITS);

   localparam logic [2:0] ST_PUSHED  = 3'd0;
   localparam logic [2:0] ST_IGNORED = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_PULLED  = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_PULL = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_PUSH, S_MOD, S_SEARCH, S_DIV, S_RD_PICK, S_RD_LAST, S_WRITE, S_DONE
   } state_type;
endpackage

[rtl/core/wrp_ram.sv]
// generic single port ram with registered read
module wrp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/weighted_random_picker_unit.sv]
// top level of the weighted random picker
//
// a pool of identifiers held in one bucket per integer weight (1 to 16)
// req channel: req_kind 0 pushes req_item_id under req_item_weight, 1 pulls
//   an identifier picked at random with probability proportional to weight,
//   using req_random_draw reduced modulo the total weight
// rsp channel: one word per request with picked id, valid flag, status and
//   the total weight after the operation
// a push writes the item ram and its bookkeeping, then loads the result; a pull
//   runs a bit serial modulo of the draw, a walk over the bucket boundaries, a
//   bit serial division by the weight and the read, read, write of the item
//   ram, then loads the result
// a pull from an empty pool skips from the modulo step to the result; the unit
//   returns to idle after each request and takes no new one before it is back
// one request is worked on at a time; req_stall is high while it runs
// the result register lets the next request be accepted while a word waits;
//   a finished request stalls in its last step until the receiver takes
//   the previous word
// reset clears the bucket counts, boundaries and totals; the item ram is
//   not cleared as only entries below a bucket's count are ever read
module weighted_random_picker_unit
   import wrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_item_id,
   input  logic [31:0] req_item_weight,
   input  logic [31:0] req_random_draw,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_picked_id,
   output logic        rsp_picked_valid,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_total_weight_now
);
   state_type state_ff, state_in;

   // latched request
   logic                 kind_ff;
   logic [ID_WIDTH-1:0]  id_ff;
   logic [31:0]          weight_ff;
   logic [DRAW_BITS-1:0] draw_ff;

   // pool bookkeeping
   logic [CNT_BITS-1:0] count_ff [MAX_WEIGHT];
   logic [TW_BITS-1:0]  bound_ff [MAX_WEIGHT];
   logic [TW_BITS-1:0]  total_ff;
   logic [8:0]          items_ff;

   // pull working registers
   logic [BIT_CNT_BITS-1:0] bit_ff;
   logic [TW_BITS:0]        rem_ff;
   logic [BKT_BITS-1:0]     bkt_ff;
   logic [TW_BITS-1:0]      quo_ff;
   logic [WGT_BITS:0]       drem_ff;
   logic [SLOT_BITS-1:0]    idx_ff;
   logic [ID_WIDTH-1:0]     pick_ff;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_id_ff;
   logic        rsp_pv_ff;
   logic [2:0]  rsp_status_ff;
   logic [2:0]  status_ff;

   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_addr;
   logic [ID_WIDTH-1:0]  ram_wdata, ram_rdata;

   wrp_ram #(.WIDTH(ID_WIDTH), .DEPTH(STORE_SIZE)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // push decode
   logic [WGT_BITS-1:0] push_w;
   logic [BKT_BITS-1:0] push_b;
   logic                push_ignore, push_full;
   always_comb begin
      if (weight_ff > 32'(MAX_WEIGHT)) begin
         push_w = WGT_BITS'(MAX_WEIGHT);
      end else begin
         push_w = weight_ff[WGT_BITS-1:0];
      end
      push_b      = BKT_BITS'(push_w - WGT_BITS'(1));
      push_ignore = (weight_ff == 32'd0) || (id_ff == {ID_WIDTH{1'b1}});
      push_full   = (count_ff[push_b] >= CNT_BITS'(BUCKET_DEPTH));
   end

   // modulo step and division step
   logic [TW_BITS:0]    mod_try;
   logic                mod_ge;
   logic [WGT_BITS:0]   div_try;
   logic [WGT_BITS-1:0] pull_w;
   logic                div_ge;
   logic [CNT_BITS-1:0] last_cnt;
   logic [SLOT_BITS-1:0] last_idx;
   always_comb begin
      mod_try  = {rem_ff[TW_BITS-1:0], draw_ff[bit_ff]};
      mod_ge   = (mod_try >= {1'b0, total_ff});
      pull_w   = WGT_BITS'(bkt_ff) + WGT_BITS'(1);
      div_try  = {drem_ff[WGT_BITS-1:0], quo_ff[TW_BITS-1]};
      div_ge   = (div_try >= {1'b0, pull_w});
      last_cnt = count_ff[bkt_ff] - CNT_BITS'(1);
      last_idx = last_cnt[SLOT_BITS-1:0];
   end

   logic search_hit;
   assign search_hit = (count_ff[bkt_ff] != '0) && (bound_ff[bkt_ff] <= rem_ff[TW_BITS-1:0]);

   logic rsp_free;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // next state and ram control
   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_addr  = {bkt_ff, idx_ff};
      ram_wdata = ram_rdata;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == KIND_PUSH) ? S_PUSH : S_MOD;
            end
         end
         S_PUSH: begin
            ram_addr  = {push_b, count_ff[push_b][SLOT_BITS-1:0]};
            ram_wdata = id_ff;
            ram_we    = !push_ignore && !push_full;
            state_in  = S_DONE;
         end
         S_MOD: begin
            if (total_ff == '0) begin
               state_in = S_DONE;
            end else if (bit_ff == '0) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (search_hit) begin
               state_in = S_DIV;
            end else if (bkt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (bit_ff == '0) begin
               state_in = S_RD_PICK;
            end
         end
         S_RD_PICK: begin
            state_in = S_RD_LAST;
         end
         S_RD_LAST: begin
            ram_addr = {bkt_ff, last_idx};
            state_in = S_WRITE;
         end
         S_WRITE: begin
            ram_we   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // bookkeeping and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_WEIGHT; k++) begin
            count_ff[k] <= '0;
            bound_ff[k] <= '0;
         end
         total_ff     <= '0;
         items_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff   <= req_kind;
                  id_ff     <= req_item_id;
                  weight_ff <= req_item_weight;
                  draw_ff   <= req_random_draw;
                  bit_ff    <= BIT_CNT_BITS'(DRAW_BITS - 1);
                  rem_ff    <= '0;
                  bkt_ff    <= BKT_BITS'(MAX_WEIGHT - 1);
               end
            end
            S_PUSH: begin
               if (push_ignore) begin
                  status_ff <= ST_IGNORED;
               end else if (push_full) begin
                  status_ff <= ST_FULL;
               end else begin
                  status_ff        <= ST_PUSHED;
                  count_ff[push_b] <= count_ff[push_b] + CNT_BITS'(1);
                  total_ff         <= total_ff + TW_BITS'(push_w);
                  items_ff         <= items_ff + 9'd1;
                  for (int k = 0; k < MAX_WEIGHT; k++) begin
                     if (k > int'(push_b)) begin
                        bound_ff[k] <= bound_ff[k] + TW_BITS'(push_w);
                     end
                  end
               end
            end
            S_MOD: begin
               status_ff <= ST_EMPTY;
               rem_ff    <= mod_ge ? (mod_try - {1'b0, total_ff}) : mod_try;
               bit_ff    <= bit_ff - BIT_CNT_BITS'(1);
            end
            S_SEARCH: begin
               if (search_hit) begin
                  quo_ff  <= rem_ff[TW_BITS-1:0] - bound_ff[bkt_ff];
                  drem_ff <= '0;
                  bit_ff  <= BIT_CNT_BITS'(TW_BITS - 1);
               end else if (bkt_ff != '0) begin
                  bkt_ff <= bkt_ff - BKT_BITS'(1);
               end
            end
            S_DIV: begin
               drem_ff <= div_ge ? (div_try - {1'b0, pull_w}) : div_try;
               quo_ff  <= {quo_ff[TW_BITS-2:0], div_ge};
               bit_ff  <= bit_ff - BIT_CNT_BITS'(1);
               if (bit_ff == '0) begin
                  // guard against an index past the bucket's last entry
                  if ({quo_ff[TW_BITS-2:0], div_ge} > TW_BITS'(last_cnt)) begin
                     idx_ff <= last_idx;
                  end else begin
                     idx_ff <= SLOT_BITS'({quo_ff[TW_BITS-2:0], div_ge});
                  end
               end
            end
            S_RD_LAST: begin
               pick_ff <= ram_rdata;
            end
            S_WRITE: begin
               status_ff        <= ST_PULLED;
               count_ff[bkt_ff] <= last_cnt;
               total_ff         <= total_ff - TW_BITS'(pull_w);
               if (items_ff != '0) begin
                  items_ff <= items_ff - 9'd1;
               end
               for (int k = 0; k < MAX_WEIGHT; k++) begin
                  if (k > int'(bkt_ff)) begin
                     bound_ff[k] <= bound_ff[k] - TW_BITS'(pull_w);
                  end
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_status_ff <= status_ff;
                  if ((kind_ff == KIND_PULL) && (status_ff == ST_PULLED)) begin
                     rsp_id_ff <= 32'(pick_ff);
                     rsp_pv_ff <= 1'b1;
                  end else begin
                     rsp_id_ff <= 32'hFFFF_FFFF;
                     rsp_pv_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   logic [TW_BITS-1:0] rsp_tw_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) begin
         rsp_tw_ff <= total_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_picked_id        = rsp_id_ff;
   assign rsp_picked_valid     = rsp_pv_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_total_weight_now = rsp_tw_ff;

   // the heaviest boundary plus the heaviest bucket's count times its weight equals the total
   a_total_sum: assert property (@(posedge clock) disable iff (reset)
      (bound_ff[MAX_WEIGHT-1] + TW_BITS'(count_ff[MAX_WEIGHT-1]) * TW_BITS'(MAX_WEIGHT))
         == total_ff)
      else $error("boundary and total weight disagree");

   // an empty pool holds no weight
   a_empty_pool: assert property (@(posedge clock) disable iff (reset)
      (items_ff == '0) |-> (total_ff == '0))
      else $error("weight left in an empty pool");

   // only a pull that removed an item reports a valid id
   a_pick_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pv_ff) |-> (rsp_status_ff == ST_PULLED))
      else $error("valid pick with wrong status");
endmodule
